>>> rtl/core/nmea_gga_field_extractor_assert.svh
// Assertion macros used by the NMEA GGA field extractor RTL.
`ifndef NMEA_GGA_FIELD_EXTRACTOR_ASSERT_SVH
`define NMEA_GGA_FIELD_EXTRACTOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NGA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("NGA assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define NGA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("NGA assertion failed");

`endif

>>> rtl/core/nga_pkg.sv
// Types, codes and constant tables of the NMEA GGA field extractor.
package nga_pkg;

    localparam logic [1:0] KIND_NUM  = 2'd0;
    localparam logic [1:0] KIND_DIR  = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_W     = 8'h57;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_Z = 8'h7A;

    localparam logic [3:0] HDR_LEN = 4'd6;
    localparam logic [39:0] MAG_MAX = 40'd549755813887;

    typedef struct packed {
        logic [1:0]         kind;
        logic [3:0]         field_number;
        logic signed [39:0] fixed_value;
        logic [7:0]         direction;
        logic               success;
        logic [2:0]         emitted_count;
        logic               run_end;
    } t_result;

    typedef struct packed {
        logic [1:0] n;
        t_result    r0;
        t_result    r1;
    } t_push;

    typedef struct packed {
        logic [2:0] count;
        logic       room2;
    } t_resq_status;

    // Characters of the expected sentence header "$GPGGA".
    function automatic logic [7:0] hdr_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0: c = 8'h24;
            3'd1: c = 8'h47;
            3'd2: c = 8'h50;
            3'd3: c = 8'h47;
            3'd4: c = 8'h47;
            3'd5: c = 8'h41;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [19:0] pow10(input logic [2:0] j);
        logic [19:0] p;
        case (j)
            3'd0: p = 20'd1;
            3'd1: p = 20'd10;
            3'd2: p = 20'd100;
            3'd3: p = 20'd1000;
            3'd4: p = 20'd10000;
            3'd5: p = 20'd100000;
            3'd6: p = 20'd1000000;
            default: p = 20'd0;
        endcase
        return p;
    endfunction

endpackage

>>> rtl/core/nga_if.sv
// Valid/ready channel interfaces for sentence bytes and extracted results.
interface nga_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       last_byte;

    modport source (output valid, output byte_in, output last_byte, input ready);
    modport sink (input valid, input byte_in, input last_byte, output ready);
endinterface

interface nga_result_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [3:0]         field_number;
    logic signed [39:0] fixed_value;
    logic [7:0]         direction;
    logic               success;
    logic [2:0]         emitted_count;
    logic               run_end;

    modport source (output valid, output kind, output field_number, output fixed_value,
                    output direction, output success, output emitted_count,
                    output run_end, input ready);
    modport sink (input valid, input kind, input field_number, input fixed_value,
                  input direction, input success, input emitted_count,
                  input run_end, output ready);
endinterface

>>> rtl/core/nga_resq.sv
// Four-entry result queue that takes up to two results per cycle and delivers one.
module nga_resq
    import nga_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_push               i_push,
    output t_resq_status        o_status,
    nga_result_if.source        o_result
);

    localparam int DEPTH = 4;

    t_result    r_q [DEPTH];
    t_result    n_q [DEPTH];
    logic [2:0] r_cnt;
    logic [2:0] n_cnt;
    logic [2:0] cnt_pop;
    logic [1:0] w0;
    logic [1:0] w1;
    logic       pop;

    assign pop = o_result.valid && o_result.ready;

    always_comb begin
        n_q = r_q;
        cnt_pop = r_cnt;
        if (pop) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                n_q[i] = r_q[i + 1];
            end
            cnt_pop = r_cnt - 3'd1;
        end
        w0 = cnt_pop[1:0];
        w1 = cnt_pop[1:0] + 2'd1;
        if (i_push.n != 2'd0) begin
            n_q[w0] = i_push.r0;
        end
        if (i_push.n == 2'd2) begin
            n_q[w1] = i_push.r1;
        end
        n_cnt = cnt_pop + {1'b0, i_push.n};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_q <= n_q;
    end

    assign o_status.count = r_cnt;
    assign o_status.room2 = (r_cnt <= 3'(DEPTH - 2));

    assign o_result.valid         = (r_cnt != 3'd0);
    assign o_result.kind          = r_q[0].kind;
    assign o_result.field_number  = r_q[0].field_number;
    assign o_result.fixed_value   = r_q[0].fixed_value;
    assign o_result.direction     = r_q[0].direction;
    assign o_result.success       = r_q[0].success;
    assign o_result.emitted_count = r_q[0].emitted_count;
    assign o_result.run_end       = r_q[0].run_end;

endmodule

>>> rtl/core/nmea_gga_field_extractor.sv
// Top level of the NMEA GGA field extractor: byte parser state and result queue.
//
// The block takes a GGA sentence one byte per item and splits it at commas. Field 0
// must start with "$GPGGA", otherwise the sentence ends at its comma. Fields 1, 2
// and 4 (time, latitude, longitude), when closed by a comma and non-empty, give a
// signed fixed-point result scaled by ten to the FRAC_DIGITS (extra fraction digits
// truncated, magnitude saturated at 2^39-1, text without a digit gives 0). Fields 3
// and 5 give their first letter, upper-cased, when it is N/S or E/W. A NUL, CR or
// LF byte, a byte flagged last_byte, or the comma closing field FIELD_LIMIT-1 ends
// the sentence with a done result that reports how many fields were emitted. After
// an end on a byte without last_byte, bytes are dropped up to and including the next
// byte flagged last_byte. Rate: one byte per cycle while input ready is high; all
// parsing of a byte is one pass of logic from the parser registers into a four-entry
// result queue. A byte gives zero, one or two results; the queue delivers one per
// cycle while the output is ready, the field result of a comma before its done
// result. Input ready is high while the queue holds at most two results, so a
// stalled output side holds the input off after three or four results.
module nmea_gga_field_extractor
    import nga_pkg::*;
#(
    parameter int FRAC_DIGITS = 5,
    parameter int FIELD_LIMIT = 11
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    nga_byte_if.sink      i_byte,
    nga_result_if.source  o_result
);

    localparam logic PH_RUN   = 1'b0;
    localparam logic PH_DRAIN = 1'b1;

    localparam logic [2:0] FD  = 3'(FRAC_DIGITS);
    localparam logic [4:0] FLM = 5'(FIELD_LIMIT);

    // Parser state. The accumulator holds the magnitude already scaled by the
    // fraction digits still missing, so the result needs no final multiply.
    logic        r_phase,     n_phase;
    logic [3:0]  r_field,     n_field;
    logic [3:0]  r_flen,      n_flen;
    logic        r_hdr_ok,    n_hdr_ok;
    logic [7:0]  r_first,     n_first;
    logic [39:0] r_acc,       n_acc;
    logic        r_neg,       n_neg;
    logic        r_point,     n_point;
    logic        r_stop,      n_stop;
    logic        r_digits,    n_digits;
    logic        r_begun,     n_begun;
    logic [2:0]  r_fseen,     n_fseen;
    logic [2:0]  r_emitted,   n_emitted;

    t_push        push;
    t_resq_status q_stat;
    logic         accept;
    logic [7:0]   c;
    logic         last;

    // Datapath pieces of the digit update.
    logic [3:0]  digit;
    logic        is_digit;
    logic [2:0]  frac_pos;
    logic [23:0] int_add;
    logic [23:0] frac_add;
    logic [44:0] int_sum;
    logic [40:0] frac_sum;
    logic [39:0] int_acc;
    logic [39:0] frac_acc;

    // Values offered at a closing comma.
    logic [39:0] mag;
    logic [39:0] num_val;
    logic [7:0]  dir_up;
    logic        dir_ok;
    logic        num_fld;
    logic        emit;
    logic        sent_end;
    t_result     field_res;

    assign accept = i_byte.valid && i_byte.ready;
    assign i_byte.ready = q_stat.room2;
    assign c = i_byte.byte_in;
    assign last = i_byte.last_byte;

    assign digit    = 4'(c - CH_0);
    assign is_digit = (c >= CH_0) && (c <= CH_9);
    assign frac_pos = FD - r_fseen - 3'd1;
    assign int_add  = 24'(digit) * 24'(pow10(FD));
    assign frac_add = 24'(digit) * 24'(pow10(frac_pos));
    assign int_sum  = {2'b00, r_acc, 3'b000} + {4'b0000, r_acc, 1'b0} + 45'(int_add);
    assign frac_sum = {1'b0, r_acc} + 41'(frac_add);
    assign int_acc  = (int_sum > 45'(MAG_MAX)) ? MAG_MAX : int_sum[39:0];
    assign frac_acc = (frac_sum > 41'(MAG_MAX)) ? MAG_MAX : frac_sum[39:0];

    assign mag     = r_digits ? r_acc : 40'd0;
    assign num_val = (r_neg && (mag != 40'd0)) ? (40'd0 - mag) : mag;
    assign dir_up  = ((r_first >= CH_LOW_A) && (r_first <= CH_LOW_Z)) ?
                     (r_first - 8'd32) : r_first;
    assign num_fld = (r_field == 4'd1) || (r_field == 4'd2) || (r_field == 4'd4);
    assign dir_ok  = ((r_field == 4'd3) && ((dir_up == CH_N) || (dir_up == CH_S))) ||
                     ((r_field == 4'd5) && ((dir_up == CH_E) || (dir_up == CH_W)));
    assign emit    = (r_field != 4'd0) && (r_flen != 4'd0) && (num_fld || dir_ok);
    assign sent_end = (({1'b0, r_field} + 5'd1) >= FLM) || last;

    always_comb begin
        field_res = '0;
        if (num_fld) begin
            field_res.kind        = KIND_NUM;
            field_res.fixed_value = num_val;
        end else begin
            field_res.kind      = KIND_DIR;
            field_res.direction = dir_up;
        end
        field_res.field_number = r_field;
    end

    function automatic t_result make_done(input logic [3:0] fld, input logic [2:0] cnt);
        t_result r;
        r = '0;
        r.kind          = KIND_DONE;
        r.field_number  = fld;
        r.success       = (cnt != 3'd0);
        r.emitted_count = cnt;
        r.run_end       = 1'b1;
        return r;
    endfunction

    always_comb begin
        n_phase   = r_phase;
        n_field   = r_field;
        n_flen    = r_flen;
        n_hdr_ok  = r_hdr_ok;
        n_first   = r_first;
        n_acc     = r_acc;
        n_neg     = r_neg;
        n_point   = r_point;
        n_stop    = r_stop;
        n_digits  = r_digits;
        n_begun   = r_begun;
        n_fseen   = r_fseen;
        n_emitted = r_emitted;
        push      = '0;

        if (accept) begin
            if (r_phase == PH_DRAIN) begin
                if (last) begin
                    n_phase = PH_RUN;
                end
            end else if ((c == CH_NUL) || (c == CH_CR) || (c == CH_LF)) begin
                push.n  = 2'd1;
                push.r0 = make_done(r_field, r_emitted);
            end else if (c == CH_COMMA) begin
                if ((r_field == 4'd0) && !(r_hdr_ok && (r_flen >= HDR_LEN))) begin
                    push.n  = 2'd1;
                    push.r0 = make_done(4'd0, r_emitted);
                end else if (emit) begin
                    n_emitted = r_emitted + 3'd1;
                    push.r0 = field_res;
                    if (sent_end) begin
                        push.n  = 2'd2;
                        push.r1 = make_done(r_field, r_emitted + 3'd1);
                    end else begin
                        push.n = 2'd1;
                        push.r0.run_end = 1'b1;
                    end
                end else if (sent_end) begin
                    push.n  = 2'd1;
                    push.r0 = make_done(r_field, r_emitted);
                end
                n_field = r_field + 4'd1;
            end else begin
                // Ordinary character: header check, length, and number parsing.
                if (r_flen == 4'd0) begin
                    n_first = c;
                end
                if ((r_field == 4'd0) && (r_flen < HDR_LEN) && (c != hdr_char(r_flen[2:0])))
                begin
                    n_hdr_ok = 1'b0;
                end
                if (r_flen != 4'd15) begin
                    n_flen = r_flen + 4'd1;
                end
                if (!r_stop) begin
                    if (is_digit) begin
                        n_begun  = 1'b1;
                        n_digits = 1'b1;
                        if (r_point) begin
                            if (r_fseen < FD) begin
                                n_acc   = frac_acc;
                                n_fseen = r_fseen + 3'd1;
                            end
                        end else begin
                            n_acc = int_acc;
                        end
                    end else if ((c == CH_POINT) && !r_point) begin
                        n_begun = 1'b1;
                        n_point = 1'b1;
                    end else if (((c == CH_PLUS) || (c == CH_MINUS)) && !r_begun) begin
                        n_begun = 1'b1;
                        if (c == CH_MINUS) begin
                            n_neg = 1'b1;
                        end
                    end else if (((c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) ||
                                  (c == CH_FF)) && !r_begun) begin
                        n_stop = 1'b0;
                    end else begin
                        n_stop = 1'b1;
                    end
                end
                if (last) begin
                    push.n  = 2'd1;
                    push.r0 = make_done(r_field, r_emitted);
                end
            end

            // A comma always starts a new field.
            if ((r_phase == PH_RUN) && (c == CH_COMMA)) begin
                n_flen   = 4'd0;
                n_first  = 8'd0;
                n_acc    = 40'd0;
                n_neg    = 1'b0;
                n_point  = 1'b0;
                n_stop   = 1'b0;
                n_digits = 1'b0;
                n_begun  = 1'b0;
                n_fseen  = 3'd0;
            end

            // Any done result closes the sentence and restarts the parser.
            if ((r_phase == PH_RUN) && (((push.n == 2'd1) && (push.r0.kind == KIND_DONE)) ||
                                        (push.n == 2'd2))) begin
                n_field   = 4'd0;
                n_flen    = 4'd0;
                n_hdr_ok  = 1'b1;
                n_first   = 8'd0;
                n_acc     = 40'd0;
                n_neg     = 1'b0;
                n_point   = 1'b0;
                n_stop    = 1'b0;
                n_digits  = 1'b0;
                n_begun   = 1'b0;
                n_fseen   = 3'd0;
                n_emitted = 3'd0;
                n_phase   = last ? PH_RUN : PH_DRAIN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_RUN;
            r_field   <= 4'd0;
            r_flen    <= 4'd0;
            r_hdr_ok  <= 1'b1;
            r_first   <= 8'd0;
            r_acc     <= 40'd0;
            r_neg     <= 1'b0;
            r_point   <= 1'b0;
            r_stop    <= 1'b0;
            r_digits  <= 1'b0;
            r_begun   <= 1'b0;
            r_fseen   <= 3'd0;
            r_emitted <= 3'd0;
        end else begin
            r_phase   <= n_phase;
            r_field   <= n_field;
            r_flen    <= n_flen;
            r_hdr_ok  <= n_hdr_ok;
            r_first   <= n_first;
            r_acc     <= n_acc;
            r_neg     <= n_neg;
            r_point   <= n_point;
            r_stop    <= n_stop;
            r_digits  <= n_digits;
            r_begun   <= n_begun;
            r_fseen   <= n_fseen;
            r_emitted <= n_emitted;
        end
    end

    nga_resq u_resq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_status (q_stat),
        .o_result (o_result)
    );

`include "nmea_gga_field_extractor_assert.svh"

    // The queue never overfills, given that ready keeps room for two results.
    `NGA_ASSERT_IMP(a_queue_bound, i_clk, i_rst_n, 1'b1, q_stat.count <= 3'd4)
    // A byte flagged last always leaves a fresh sentence behind it.
    `NGA_ASSERT_NXT(a_last_restarts, i_clk, i_rst_n, accept && last,
        (r_phase == PH_RUN) && (r_field == 4'd0) && (r_emitted == 3'd0))
    // Only fields 1 to 5 are emitted, so the count stays at five or below.
    `NGA_ASSERT_IMP(a_emit_bound, i_clk, i_rst_n, 1'b1, r_emitted <= 3'd5)
    // A done result is always the final result of its byte.
    `NGA_ASSERT_IMP(a_done_run_end, i_clk, i_rst_n,
        o_result.valid && (o_result.kind == KIND_DONE), o_result.run_end)

endmodule

>>> tb/nmea_gga_field_extractor_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the NMEA GGA field extractor with a byte-level parser model.
module nmea_gga_field_extractor_tb
    import nga_pkg::*;
();

    localparam int FRAC_DIGITS  = 5;
    localparam int FIELD_LIMIT  = 11;
    localparam int RANDOM_BYTES = 1950;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 16;
    localparam int DIRECTED_ROWS = 27;

    localparam logic [47:0] GGA_TAG = "$GPGGA";

    localparam logic [7:0] PAD_CHARS [4]  = '{CH_SPACE, CH_TAB, CH_VT, CH_FF};
    localparam logic [7:0] JUNK_CHARS [8] = '{"e", "E", CH_POINT, CH_PLUS, CH_MINUS,
                                              CH_SPACE, "x", CH_TAB};
    localparam logic [7:0] DIR_CHARS [8]  = '{CH_N, CH_S, CH_E, CH_W, "n", "s", "e", "w"};
    localparam logic [7:0] END_CHARS [3]  = '{CH_CR, CH_LF, CH_NUL};

    typedef enum logic {PH_RUNNING, PH_DRAINING} t_sentence_phase;
    typedef enum int {RDY_ALWAYS, RDY_RANDOM, RDY_BURSTY} t_ready_mode;

    // One byte of stimulus; typed rows carry the one result they must produce.
    typedef struct packed {
        logic [7:0] ch;
        logic       lst;
        logic       typed;
        t_result    want;
    } t_stim_row;

    localparam t_result NOT_TYPED = '0;

    // Directed opening: empty sentences, a full GGA sentence that reaches the field
    // limit, then a NUL that ends a sentence without last_byte and a dropped 0xFF.
    localparam t_stim_row DIRECTED [DIRECTED_ROWS] = '{
        '{CH_CR,    1'b1, 1'b1, '{KIND_DONE, 4'd0, 40'sd0, 8'h00, 1'b0, 3'd0, 1'b1}},
        '{CH_COMMA, 1'b1, 1'b1, '{KIND_DONE, 4'd0, 40'sd0, 8'h00, 1'b0, 3'd0, 1'b1}},
        '{"$",      1'b0, 1'b0, NOT_TYPED},
        '{"G",      1'b0, 1'b0, NOT_TYPED},
        '{"P",      1'b0, 1'b0, NOT_TYPED},
        '{"G",      1'b0, 1'b0, NOT_TYPED},
        '{"G",      1'b0, 1'b0, NOT_TYPED},
        '{"A",      1'b0, 1'b0, NOT_TYPED},
        '{CH_COMMA, 1'b0, 1'b0, NOT_TYPED},
        '{CH_MINUS, 1'b0, 1'b0, NOT_TYPED},
        '{CH_POINT, 1'b0, 1'b0, NOT_TYPED},
        '{"5",      1'b0, 1'b0, NOT_TYPED},
        '{CH_COMMA, 1'b0, 1'b0, NOT_TYPED},
        '{CH_COMMA, 1'b0, 1'b0, NOT_TYPED},
        '{"s",      1'b0, 1'b0, NOT_TYPED},
        '{CH_COMMA, 1'b0, 1'b1, '{KIND_DIR, 4'd3, 40'sd0, CH_S, 1'b0, 3'd0, 1'b1}},
        '{"x",      1'b0, 1'b0, NOT_TYPED},
        '{CH_COMMA, 1'b0, 1'b1, '{KIND_NUM, 4'd4, 40'sd0, 8'h00, 1'b0, 3'd0, 1'b1}},
        '{"w",      1'b0, 1'b0, NOT_TYPED},
        '{CH_COMMA, 1'b0, 1'b1, '{KIND_DIR, 4'd5, 40'sd0, CH_W, 1'b0, 3'd0, 1'b1}},
        '{CH_COMMA, 1'b0, 1'b0, NOT_TYPED},
        '{CH_COMMA, 1'b0, 1'b0, NOT_TYPED},
        '{CH_COMMA, 1'b0, 1'b0, NOT_TYPED},
        '{CH_COMMA, 1'b0, 1'b0, NOT_TYPED},
        '{CH_COMMA, 1'b1, 1'b1, '{KIND_DONE, 4'd10, 40'sd0, 8'h00, 1'b1, 3'd4, 1'b1}},
        '{CH_NUL,   1'b0, 1'b1, '{KIND_DONE, 4'd0, 40'sd0, 8'h00, 1'b0, 3'd0, 1'b1}},
        '{8'hFF,    1'b1, 1'b0, NOT_TYPED}
    };

    logic i_clk;
    logic i_rst_n;

    nga_byte_if   byte_ch();
    nga_result_if result_ch();

    nmea_gga_field_extractor #(
        .FRAC_DIGITS(FRAC_DIGITS),
        .FIELD_LIMIT(FIELD_LIMIT)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch),
        .o_result(result_ch)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    t_stim_row sentence_bytes[$];
    t_result   byte_results[$];
    t_result   expected_results[$];
    int        bytes_taken = 0;
    int        fail_count = 0;
    int        idle_cycles = 0;

    // Parser model state.
    t_sentence_phase phase;
    logic [3:0]      fld_idx;
    logic [3:0]      fld_len;
    logic            tag_ok;
    logic [7:0]      lead_ch;
    logic [39:0]     mag;
    logic            neg;
    logic            point_seen;
    logic            halted;
    logic            got_digit;
    logic            begun;
    logic [2:0]      frac_cnt;
    logic [2:0]      emit_cnt;

    function automatic logic [7:0] tag_char(int idx);
        return GGA_TAG[8 * (5 - idx) +: 8];
    endfunction

    // Printable character that never splits a field.
    function automatic logic [7:0] text_char();
        logic [7:0] ch;
        ch = 8'($urandom_range(8'h20, 8'h7E));
        return (ch == CH_COMMA) ? CH_POINT : ch;
    endfunction

    function automatic logic [7:0] digit_char();
        return CH_0 + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [39:0] times_ten_plus(logic [39:0] a, logic [3:0] d);
        logic [43:0] wide;
        wide = 44'(a) * 44'd10 + 44'(d);
        return (wide > 44'(MAG_MAX)) ? MAG_MAX : wide[39:0];
    endfunction

    // Scale the kept digits up to FRAC_DIGITS decimals and apply the sign.
    function automatic logic signed [39:0] field_fixed_value();
        logic [39:0] m;
        m = got_digit ? mag : 40'd0;
        for (int i = int'(frac_cnt); i < FRAC_DIGITS; i++)
            m = times_ten_plus(m, 4'd0);
        return (neg && m != 40'd0) ? -m : m;
    endfunction

    function void clear_field();
        fld_len    = '0;
        lead_ch    = '0;
        mag        = '0;
        neg        = 1'b0;
        point_seen = 1'b0;
        halted     = 1'b0;
        got_digit  = 1'b0;
        begun      = 1'b0;
        frac_cnt   = '0;
    endfunction

    function void clear_sentence();
        clear_field();
        fld_idx  = '0;
        tag_ok   = 1'b1;
        emit_cnt = '0;
    endfunction

    function void add_result(logic [1:0] kind, logic [3:0] fld, logic signed [39:0] val,
                             logic [7:0] dir, logic succ, logic [2:0] cnt);
        t_result r;
        r = '0;
        r.kind          = kind;
        r.field_number  = fld;
        r.fixed_value   = val;
        r.direction     = dir;
        r.success       = succ;
        r.emitted_count = cnt;
        byte_results.push_back(r);
    endfunction

    function void end_sentence(logic [3:0] fld, logic lst);
        add_result(KIND_DONE, fld, '0, '0, emit_cnt != 3'd0, emit_cnt);
        clear_sentence();
        phase = lst ? PH_RUNNING : PH_DRAINING;
    endfunction

    // Prefix number scan: blanks, one sign, digits with one point, then it stops.
    function void number_byte(logic [7:0] c);
        if (halted)
            return;
        if (c >= CH_0 && c <= CH_9) begin
            begun     = 1'b1;
            got_digit = 1'b1;
            if (!point_seen) begin
                mag = times_ten_plus(mag, 4'(c - CH_0));
            end else if (frac_cnt < FRAC_DIGITS) begin
                mag      = times_ten_plus(mag, 4'(c - CH_0));
                frac_cnt = frac_cnt + 3'd1;
            end
        end else if (c == CH_POINT && !point_seen) begin
            begun      = 1'b1;
            point_seen = 1'b1;
        end else if ((c == CH_PLUS || c == CH_MINUS) && !begun) begin
            begun = 1'b1;
            if (c == CH_MINUS)
                neg = 1'b1;
        end else if ((c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF) && !begun) begin
            // Leading blanks are skipped.
        end else begin
            halted = 1'b1;
        end
    endfunction

    // Work out the results that one accepted byte causes, in order, into byte_results.
    function void parse_sentence_byte(logic [7:0] c, logic lst);
        logic [3:0] closing;
        logic [7:0] d;
        byte_results.delete();
        if (phase == PH_DRAINING) begin
            if (lst)
                phase = PH_RUNNING;
            return;
        end
        closing = fld_idx;
        if (c == CH_NUL || c == CH_CR || c == CH_LF) begin
            end_sentence(fld_idx, lst);
        end else if (c == CH_COMMA) begin
            if (fld_idx == 4'd0 && !(tag_ok && fld_len >= HDR_LEN)) begin
                end_sentence(4'd0, lst);
            end else begin
                if (fld_idx != 4'd0 && fld_len != 4'd0) begin
                    if (fld_idx == 4'd1 || fld_idx == 4'd2 || fld_idx == 4'd4) begin
                        add_result(KIND_NUM, fld_idx, field_fixed_value(), '0, 1'b0, '0);
                        emit_cnt = emit_cnt + 3'd1;
                    end else if (fld_idx == 4'd3 || fld_idx == 4'd5) begin
                        d = lead_ch;
                        if (d >= CH_LOW_A && d <= CH_LOW_Z)
                            d = d - 8'd32;
                        if ((fld_idx == 4'd3 && (d == CH_N || d == CH_S)) ||
                            (fld_idx == 4'd5 && (d == CH_E || d == CH_W))) begin
                            add_result(KIND_DIR, fld_idx, '0, d, 1'b0, '0);
                            emit_cnt = emit_cnt + 3'd1;
                        end
                    end
                end
                clear_field();
                fld_idx = fld_idx + 4'd1;
                if (fld_idx >= FIELD_LIMIT || lst)
                    end_sentence(closing, lst);
            end
        end else begin
            if (fld_len == 4'd0)
                lead_ch = c;
            if (fld_idx == 4'd0 && fld_len < HDR_LEN && c != tag_char(int'(fld_len)))
                tag_ok = 1'b0;
            if (fld_len != 4'd15)
                fld_len = fld_len + 4'd1;
            number_byte(c);
            if (lst)
                end_sentence(fld_idx, lst);
        end
        if (byte_results.size() != 0)
            byte_results[byte_results.size() - 1].run_end = 1'b1;
    endfunction

    function void add_byte(logic [7:0] ch, logic lst);
        t_stim_row row;
        row = '0;
        row.ch  = ch;
        row.lst = lst;
        sentence_bytes.push_back(row);
    endfunction

    // Random text of field f: numbers in 1, 2 and 4, letters in 3 and 5.
    function void add_field_text(int f);
        int  n;
        logic wide;
        if ($urandom_range(0, 11) == 0)
            return;
        if (f == 1 || f == 2 || f == 4) begin
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 2)) add_byte(PAD_CHARS[$urandom_range(0, 3)], 1'b0);
            case ($urandom_range(0, 3))
                0: add_byte(CH_MINUS, 1'b0);
                1: add_byte(CH_PLUS, 1'b0);
                default: ;
            endcase
            // Now and then a long run of digits drives the magnitude into saturation.
            wide = ($urandom_range(0, 9) == 0);
            n = wide ? $urandom_range(10, 16) : $urandom_range(0, 5);
            repeat (n) add_byte((wide && $urandom_range(0, 1) == 1) ? CH_9 : digit_char(), 1'b0);
            if ($urandom_range(0, 3) != 0) begin
                add_byte(CH_POINT, 1'b0);
                repeat ($urandom_range(0, 8)) add_byte(digit_char(), 1'b0);
            end
            if ($urandom_range(0, 6) == 0) begin
                add_byte(JUNK_CHARS[$urandom_range(0, 7)], 1'b0);
                repeat ($urandom_range(0, 2)) add_byte(digit_char(), 1'b0);
            end
        end else if (f == 3 || f == 5) begin
            add_byte(($urandom_range(0, 5) != 0) ? DIR_CHARS[$urandom_range(0, 7)] : text_char(),
                     1'b0);
            if ($urandom_range(0, 3) == 0)
                add_byte(text_char(), 1'b0);
        end else begin
            repeat ($urandom_range(1, 4)) add_byte(text_char(), 1'b0);
        end
    endfunction

    function void compare_field(string name, logic signed [63:0] want, logic signed [63:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    function void check_result(t_result got);
        t_result want;
        if (expected_results.size() == 0) begin
            $error("unexpected result: kind %0d field %0d", got.kind, got.field_number);
            fail_count++;
            return;
        end
        want = expected_results.pop_front();
        compare_field("kind", want.kind, got.kind);
        compare_field("field_number", want.field_number, got.field_number);
        compare_field("fixed_value", $signed(want.fixed_value), $signed(got.fixed_value));
        compare_field("direction", want.direction, got.direction);
        compare_field("success", want.success, got.success);
        compare_field("emitted_count", want.emitted_count, got.emitted_count);
        compare_field("run_end", want.run_end, got.run_end);
    endfunction

    // Results are checked before the byte of the same edge is parsed, since a byte
    // can never produce a result in the cycle in which it is taken.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (result_ch.valid && result_ch.ready)
                check_result('{result_ch.kind, result_ch.field_number, result_ch.fixed_value,
                               result_ch.direction, result_ch.success,
                               result_ch.emitted_count, result_ch.run_end});
            if (byte_ch.valid && byte_ch.ready) begin
                parse_sentence_byte(byte_ch.byte_in, byte_ch.last_byte);
                if (sentence_bytes[bytes_taken].typed)
                    expected_results.push_back(sentence_bytes[bytes_taken].want);
                else
                    foreach (byte_results[i]) expected_results.push_back(byte_results[i]);
                bytes_taken++;
            end
        end
    end

    // Result side: free-running, random, or long stalls, each for a stretch of cycles.
    t_ready_mode ready_mode = RDY_ALWAYS;
    int          mode_left = 0;
    int          stall_left = 0;

    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            ready_mode = t_ready_mode'($urandom_range(0, 2));
            mode_left  = $urandom_range(20, 200);
        end else begin
            mode_left--;
        end
        case (ready_mode)
            RDY_ALWAYS: result_ch.ready <= 1'b1;
            RDY_RANDOM: result_ch.ready <= ($urandom_range(0, 3) != 0);
            default: begin
                if (stall_left != 0) begin
                    result_ch.ready <= 1'b0;
                    stall_left--;
                end else begin
                    result_ch.ready <= 1'b1;
                    if ($urandom_range(0, 7) == 0)
                        stall_left = $urandom_range(1, 12);
                end
            end
        endcase
    end

    // Watchdog on cycles in which neither side moves an item.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("simulation failed");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        int   n;
        int   pos;
        int   nf;
        int   idx;
        int   burst;
        int   gap;
        logic extra;

        i_rst_n           = 1'b0;
        byte_ch.valid     = 1'b0;
        byte_ch.byte_in   = '0;
        byte_ch.last_byte = 1'b0;
        result_ch.ready   = 1'b0;
        phase = PH_RUNNING;
        clear_sentence();

        for (int i = 0; i < DIRECTED_ROWS; i++)
            sentence_bytes.push_back(DIRECTED[i]);

        // Random sentences: mostly GGA shaped, some with a broken header, some noise.
        // Every sentence ends on a byte with last_byte set so the next one starts clean.
        while (sentence_bytes.size() < DIRECTED_ROWS + RANDOM_BYTES) begin
            if ($urandom_range(0, 99) < 12) begin
                n = $urandom_range(1, 10);
                for (int i = 0; i < n; i++)
                    add_byte(8'($urandom), i == n - 1);
            end else begin
                n = 6;
                pos = -1;
                extra = 1'b0;
                case ($urandom_range(0, 9))
                    0: pos = $urandom_range(0, 5);
                    1: n = $urandom_range(0, 5);
                    2: extra = 1'b1;
                    default: ;
                endcase
                for (int i = 0; i < n; i++)
                    add_byte((i == pos) ? 8'($urandom) : tag_char(i), 1'b0);
                if (extra)
                    add_byte(text_char(), 1'b0);
                nf = $urandom_range(0, 12);
                for (int f = 1; f <= nf; f++) begin
                    add_byte(CH_COMMA, 1'b0);
                    add_field_text(f);
                end
                case ($urandom_range(0, 4))
                    0, 1: begin
                        add_byte(CH_COMMA, 1'b0);
                        add_byte(END_CHARS[$urandom_range(0, 2)], 1'($urandom_range(0, 1)));
                    end
                    2: add_byte(CH_COMMA, 1'b1);
                    3: sentence_bytes[sentence_bytes.size() - 1].lst = 1'b1;
                    default: add_byte(END_CHARS[$urandom_range(0, 2)], 1'($urandom_range(0, 1)));
                endcase
            end
            if (!sentence_bytes[sentence_bytes.size() - 1].lst) begin
                repeat ($urandom_range(0, 3)) add_byte(8'($urandom), 1'b0);
                add_byte(8'($urandom), 1'b1);
            end
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sender: bursts of random length with random gaps in between.
        idx = 0;
        while (idx < sentence_bytes.size()) begin
            burst = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
            for (int k = 0; k < burst && idx < sentence_bytes.size(); k++) begin
                byte_ch.valid     <= 1'b1;
                byte_ch.byte_in   <= sentence_bytes[idx].ch;
                byte_ch.last_byte <= sentence_bytes[idx].lst;
                do @(posedge i_clk); while (!byte_ch.ready);
                idx++;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                byte_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        byte_ch.valid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
